[src/olid_pkg.sv]
// ----------------------------------------------------------------------------
// olid_pkg: shared definitions for the ordered list
// Sizes, operation and status codes, and the per-cell shift command.
// ----------------------------------------------------------------------------
`default_nettype none

package olid_pkg;

  // List size and field widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STAT_W   = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_END   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_INDEX = 2'd3;

  // What one cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

endpackage

`default_nettype wire

[src/olid_if.sv]
// ----------------------------------------------------------------------------
// olid_if: valid/ready channels of the ordered list
// One interface for the operation words and one for the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface olid_in_if;
  logic                                valid;
  logic                                ready;
  logic        [olid_pkg::FUNC_W-1:0]  func;
  logic        [olid_pkg::POS_W-1:0]   position;
  logic signed [olid_pkg::DATA_W-1:0]  item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface olid_out_if;
  logic                                valid;
  logic                                ready;
  logic        [olid_pkg::STAT_W-1:0]  status;
  logic signed [olid_pkg::DATA_W-1:0]  result_value;
  logic        [olid_pkg::CNT_W-1:0]   entry_count;
  logic                                last;

  modport source (output valid, status, result_value, entry_count, last, input ready);
  modport sink   (input valid, status, result_value, entry_count, last, output ready);
endinterface

`default_nettype wire

[src/ordered_list_insert_delete_at_index.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_at_index: bounded ordered list of 32-bit values
// Insert and delete at front, end or index, and dump, over a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, cell 0 being the head. On an
// accepted operation word an insert moves the cells from the target
// index upward one place to the right and loads the new value, a delete
// moves the cells above the target one place to the left, all in parallel.
// Every operation except dump returns one result word with last set; the
// next operation word is taken in the same cycle as that result leaves the
// output register, so inserts and deletes sustain one word per cycle when
// the sink keeps up. A dump of a non-empty list streams one result word per
// cycle from the head while the sink keeps up: the chain rotates left through
// its occupied cells so the head always sits in cell 0, and after count steps
// it is back in order. No operation word is taken while a dump runs; a dump of
// an empty list returns a single underflow word. Errors (full, empty, bad
// index) leave the list unchanged and carry a zero value. Stored entries
// have no reset; reset clears the entry count, the state and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_delete_at_index (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  olid_in_if.sink    in_i,
  olid_out_if.source out_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  localparam int unsigned CNT_W  = olid_pkg::CNT_W;
  localparam int unsigned DATA_W = olid_pkg::DATA_W;
  localparam int unsigned IDX_W  = olid_pkg::IDX_W;

  // Control state
  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] dump_idx_q, dump_idx_d;
  logic             out_valid_q, out_valid_d;

  // Output payload
  logic [olid_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [DATA_W-1:0]           out_value_q, out_value_d;
  logic [CNT_W-1:0]            out_count_q, out_count_d;
  logic                        out_last_q, out_last_d;

  // Cell chain
  logic [DATA_W-1:0]   cell_val [olid_pkg::CAPACITY];
  olid_pkg::cell_op_e  cell_op  [olid_pkg::CAPACITY];
  logic [DATA_W-1:0]   load_val;

  // Decode
  logic             out_free, accept;
  logic             is_ins, is_del, is_dump;
  logic             full, empty;
  logic [CNT_W-1:0] ins_pos, del_pos;
  logic             ins_ok, del_ok, rot_step;
  logic             dump_last;

  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign full     = (count_q == olid_pkg::CAP_CNT);
  assign empty    = (count_q == '0);

  assign is_ins  = (in_i.func == olid_pkg::FN_INS_FRONT) ||
                   (in_i.func == olid_pkg::FN_INS_END) ||
                   (in_i.func == olid_pkg::FN_INS_AT);
  assign is_del  = (in_i.func == olid_pkg::FN_DEL_FRONT) ||
                   (in_i.func == olid_pkg::FN_DEL_END) ||
                   (in_i.func == olid_pkg::FN_DEL_AT);
  assign is_dump = (in_i.func == olid_pkg::FN_DUMP);

  // Target index of the insert or delete
  always_comb begin
    priority case (in_i.func)
      olid_pkg::FN_INS_FRONT: ins_pos = '0;
      olid_pkg::FN_INS_END:   ins_pos = count_q;
      default:                ins_pos = CNT_W'(in_i.position);
    endcase
    priority case (in_i.func)
      olid_pkg::FN_DEL_FRONT: del_pos = '0;
      olid_pkg::FN_DEL_END:   del_pos = empty ? '0 : count_q - 1'b1;
      default:                del_pos = CNT_W'(in_i.position);
    endcase
  end

  assign ins_ok    = accept && is_ins && !full && (ins_pos <= count_q);
  assign del_ok    = accept && is_del && !empty && (del_pos < count_q);
  assign rot_step  = (state_q == S_DUMP) && out_free;
  assign dump_last = (dump_idx_q == count_q - 1'b1);

  // Broadcast value: the new entry on insert, the head while rotating
  assign load_val = (state_q == S_DUMP) ? cell_val[0] : in_i.item_value;

  // Per-cell command: shift right above an insert, left above a delete,
  // rotate left through the occupied cells during a dump
  always_comb begin
    for (int i = 0; i < int'(olid_pkg::CAPACITY); i++) begin
      cell_op[i] = olid_pkg::CELL_HOLD;
      if (ins_ok) begin
        if (CNT_W'(i) == ins_pos) begin
          cell_op[i] = olid_pkg::CELL_LOAD;
        end else if (CNT_W'(i) > ins_pos && CNT_W'(i) <= count_q) begin
          cell_op[i] = olid_pkg::CELL_FROM_LEFT;
        end
      end else if (del_ok) begin
        if (CNT_W'(i) >= del_pos && CNT_W'(i) + 1'b1 < count_q) begin
          cell_op[i] = olid_pkg::CELL_FROM_RIGHT;
        end
      end else if (rot_step) begin
        if (CNT_W'(i) + 1'b1 < count_q) begin
          cell_op[i] = olid_pkg::CELL_FROM_RIGHT;
        end else if (CNT_W'(i) + 1'b1 == count_q) begin
          cell_op[i] = olid_pkg::CELL_LOAD;
        end
      end
    end
  end

  for (genvar g = 0; g < int'(olid_pkg::CAPACITY); g++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;

    if (g == 0) begin : g_head
      assign left_val = cell_val[0];
    end else begin : g_body
      assign left_val = cell_val[g-1];
    end

    // Tail wraps to the head; only reached through the load bus in practice
    if (g == int'(olid_pkg::CAPACITY) - 1) begin : g_tail
      assign right_val = cell_val[0];
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end

    olid_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .load_i  (load_val),
      .left_i  (left_val),
      .right_i (right_val),
      .value_o (cell_val[g])
    );
  end

  // Sequencer and output register
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dump_idx_d   = dump_idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;

    if (accept) begin
      out_valid_d  = 1'b1;
      out_status_d = olid_pkg::ST_OK;
      out_value_d  = '0;
      out_last_d   = 1'b1;
      if (is_ins) begin
        if (full) begin
          out_status_d = olid_pkg::ST_FULL;
        end else if (!ins_ok) begin
          out_status_d = olid_pkg::ST_INDEX;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else if (is_del) begin
        if (empty) begin
          out_status_d = olid_pkg::ST_EMPTY;
        end else if (!del_ok) begin
          out_status_d = olid_pkg::ST_INDEX;
        end else begin
          out_value_d = cell_val[del_pos[IDX_W-1:0]];
          count_d     = count_q - 1'b1;
        end
      end else if (is_dump) begin
        if (empty) begin
          out_status_d = olid_pkg::ST_EMPTY;
        end else begin
          // Stream once in the dump state; no result word for the dump word itself
          out_valid_d = out_valid_q && !out_o.ready;
          state_d     = S_DUMP;
          dump_idx_d  = '0;
        end
      end
      out_count_d = count_d;
    end else if (rot_step) begin
      out_valid_d  = 1'b1;
      out_status_d = olid_pkg::ST_OK;
      out_value_d  = cell_val[0];
      out_count_d  = count_q;
      out_last_d   = dump_last;
      dump_idx_d   = dump_idx_q + 1'b1;
      if (dump_last) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign in_i.ready         = (state_q == S_IDLE) && out_free;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.result_value = out_value_q;
  assign out_o.entry_count  = out_count_q;
  assign out_o.last         = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olid_pkg::CAP_CNT)
    else $error("entry count above capacity");

  a_dump_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> !in_i.ready)
    else $error("operation word taken during dump");

  a_dump_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> dump_idx_q < count_q)
    else $error("dump index past tail");

  a_full_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_ins && full |=> out_valid_q && out_status_q == olid_pkg::ST_FULL
      && count_q == olid_pkg::CAP_CNT)
    else $error("insert into full list not reported");
`endif

endmodule

`default_nettype wire

[src/olid_cell.sv]
// ----------------------------------------------------------------------------
// olid_cell: one entry of the list chain
// Hold, load the broadcast value, or take a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module olid_cell (
  input  wire logic                           clk_i,
  input  wire olid_pkg::cell_op_e             op_i,
  input  wire logic [olid_pkg::DATA_W-1:0]    load_i,
  input  wire logic [olid_pkg::DATA_W-1:0]    left_i,
  input  wire logic [olid_pkg::DATA_W-1:0]    right_i,
  output logic      [olid_pkg::DATA_W-1:0]    value_o
);

  logic [olid_pkg::DATA_W-1:0] value_q;
  logic [olid_pkg::DATA_W-1:0] value_d;

  always_comb begin
    unique case (op_i)
      olid_pkg::CELL_LOAD:       value_d = load_i;
      olid_pkg::CELL_FROM_LEFT:  value_d = left_i;
      olid_pkg::CELL_FROM_RIGHT: value_d = right_i;
      default:                   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire
